>>> src/rhs_pkg.sv
// Shared types, constants and the byte-wide CRC32-C step for the record
// header scanner. No dependencies.
`default_nettype none

package rhs_pkg;

  localparam int FIELD_BITS = 48;
  localparam int LENGTH_BITS = 64;
  localparam int CRC_BITS = 32;

  localparam logic [CRC_BITS-1:0] CRC_ONES = 32'hFFFF_FFFF;
  // Reflected form of polynomial 0x1EDC6F41
  localparam logic [CRC_BITS-1:0] CRC_POLY_REFLECTED = 32'h82F6_3B78;
  localparam logic [CRC_BITS-1:0] MASK_DELTA = 32'hA282_EAD8;
  localparam int MASK_ROTATE = 15;

  localparam int HEADER_BYTES = 12;
  localparam int LENGTH_BYTES = 8;
  localparam int TRAILER_BYTES = 4;
  localparam int FRAME_OVERHEAD = 16;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_SKIP   = 3'b010,
    PH_STOP   = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_CRC_ERROR = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_SHORT_HDR = 2'd3
  } status_t;

  typedef struct packed {
    logic                  valid;
    logic [FIELD_BITS-1:0] offset;
    logic [FIELD_BITS-1:0] size;
    status_t               status;
  } result_t;

  // One byte of reflected CRC32-C, unrolled over its eight bits.
  function automatic logic [CRC_BITS-1:0] crc32c_byte(input logic [CRC_BITS-1:0] crc_in,
                                                      input logic [7:0] data);
    logic [CRC_BITS-1:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY_REFLECTED;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

>>> src/record_header_scanner_top.sv
// Top level of the record header scanner: input byte register, scan core,
// result register and the stream size register. Depends on rhs_pkg, rhs_scan.
//
// Usage:
//   Bytes of the record stream enter on in_valid/in_ready/data_byte, one
//   transfer per byte in file order. Each record is an 8-byte little-endian
//   length, a 4-byte masked CRC32-C of those bytes, the payload and a 4-byte
//   trailer. After the last header byte one result leaves on
//   out_valid/out_ready with record_offset, record_size and status; payload
//   and trailer bytes are consumed without results.
//   cfg_write/cfg_data load stream_size, the total byte count of the stream;
//   write it while the block is idle.
//   Throughput: one byte per cycle while no result waits on a low out_ready.
//   A byte waits in the input register, and the result register loads at the
//   edge on which that byte advances into the scan core.
//   An error result, or a byte at or past stream_size at a record start,
//   stops the scan; later bytes are taken and dropped until reset.
//   Reset returns the scanner to the first header byte at offset zero and
//   clears stream_size. While a result waits on a low out_ready, the result
//   register holds and the input register takes at most one more byte before in_ready drops.
`default_nettype none

module record_header_scanner_top #(
  parameter int POSITION_BITS = 48
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [47:0]      record_offset,
  output logic [47:0]      record_size,
  output logic [1:0]       status,
  input  wire logic        cfg_write,
  input  wire logic [47:0] cfg_data
);

  logic                               hold_valid;
  logic [7:0]                         hold_byte;
  logic                               advance;
  logic [rhs_pkg::FIELD_BITS-1:0]     stream_size;
  rhs_pkg::result_t                   scan_result;

  assign advance = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  rhs_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .data(hold_byte),
    .stream_size(stream_size),
    .result(scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid <= 1'b0;
      stream_size <= '0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance && scan_result.valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        stream_size <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= data_byte;
    end
    if (advance && scan_result.valid) begin
      record_offset <= scan_result.offset;
      record_size <= scan_result.size;
      status <= scan_result.status;
    end
  end

endmodule

`default_nettype wire

>>> src/rhs_scan.sv
// Record framing state: header capture, CRC check, bound check and payload
// skip, one byte per step. Depends on rhs_pkg.
`default_nettype none

module rhs_scan #(
  parameter int POSITION_BITS = 48
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              step,
  input  wire logic [7:0]                        data,
  input  wire logic [rhs_pkg::FIELD_BITS-1:0]    stream_size,
  output rhs_pkg::result_t                       result
);

  localparam int LB = rhs_pkg::LENGTH_BITS;

  rhs_pkg::phase_t            phase, phase_next;
  logic [3:0]                 header_count, header_count_next;
  logic [LB-1:0]              length_value, length_value_next;
  logic [LB:0]                len_plus16, len_plus16_next;
  logic [31:0]                crc_running, crc_running_next;
  logic [31:0]                stored_crc, stored_crc_next;
  logic [POSITION_BITS-1:0]   record_start, record_start_next;
  logic [POSITION_BITS-1:0]   byte_position, byte_position_next;
  logic [POSITION_BITS-1:0]   skip_remaining, skip_remaining_next;

  logic [LB-1:0]              pos64, ss64, start64, room;
  logic [31:0]                crc_sum, crc_masked, crc_got;
  logic [LB-1:0]              skip_len;

  always_comb begin
    pos64 = LB'(byte_position);
    ss64 = LB'(stream_size);
    start64 = LB'(record_start);
    crc_sum = crc_running ^ rhs_pkg::CRC_ONES;
    crc_masked = {crc_sum[rhs_pkg::MASK_ROTATE-1:0], crc_sum[31:rhs_pkg::MASK_ROTATE]}
                 + rhs_pkg::MASK_DELTA;
    crc_got = {data, stored_crc[23:0]};
    room = (ss64 >= start64) ? (ss64 - start64) : '0;
    skip_len = length_value + LB'(rhs_pkg::TRAILER_BYTES);

    phase_next = phase;
    header_count_next = header_count;
    length_value_next = length_value;
    len_plus16_next = len_plus16;
    crc_running_next = crc_running;
    stored_crc_next = stored_crc;
    record_start_next = record_start;
    byte_position_next = byte_position;
    skip_remaining_next = skip_remaining;
    result = '0;

    if (step) begin
      case (phase)
        rhs_pkg::PH_SKIP: begin
          byte_position_next = byte_position + 1'b1;
          if (skip_remaining != '0) begin
            skip_remaining_next = skip_remaining - 1'b1;
          end
          if (skip_remaining <= POSITION_BITS'(1)) begin
            phase_next = rhs_pkg::PH_HEADER;
          end
        end
        rhs_pkg::PH_HEADER: begin
          if (header_count == '0 && pos64 >= ss64) begin
            // end of stream: stop quietly
            phase_next = rhs_pkg::PH_STOP;
          end else if (header_count == '0 &&
                       (ss64 - pos64) < LB'(rhs_pkg::HEADER_BYTES)) begin
            phase_next = rhs_pkg::PH_STOP;
            result.valid = 1'b1;
            result.offset = pos64[rhs_pkg::FIELD_BITS-1:0];
            result.status = rhs_pkg::ST_SHORT_HDR;
          end else begin
            byte_position_next = byte_position + 1'b1;
            if (header_count == '0) begin
              record_start_next = byte_position;
              stored_crc_next = '0;
            end
            if (header_count < 4'(rhs_pkg::LENGTH_BYTES)) begin
              if (header_count == '0) begin
                length_value_next = '0;
                crc_running_next = rhs_pkg::crc32c_byte(rhs_pkg::CRC_ONES, data);
              end else begin
                crc_running_next = rhs_pkg::crc32c_byte(crc_running, data);
              end
              length_value_next[{header_count[2:0], 3'b000} +: 8] = data;
              header_count_next = header_count + 4'd1;
            end else if (header_count < 4'(rhs_pkg::HEADER_BYTES - 1)) begin
              if (header_count == 4'(rhs_pkg::LENGTH_BYTES)) begin
                len_plus16_next = (LB+1)'(length_value) + (LB+1)'(rhs_pkg::FRAME_OVERHEAD);
              end
              stored_crc_next[{header_count[1:0], 3'b000} +: 8] = data;
              header_count_next = header_count + 4'd1;
            end else begin
              // last CRC byte: check and report
              header_count_next = '0;
              crc_running_next = rhs_pkg::CRC_ONES;
              stored_crc_next = crc_got;
              result.valid = 1'b1;
              result.offset = start64[rhs_pkg::FIELD_BITS-1:0];
              if (crc_masked != crc_got) begin
                phase_next = rhs_pkg::PH_STOP;
                result.status = rhs_pkg::ST_CRC_ERROR;
              end else if (len_plus16 > {1'b0, room}) begin
                phase_next = rhs_pkg::PH_STOP;
                result.status = rhs_pkg::ST_TRUNCATED;
              end else begin
                skip_remaining_next = skip_len[POSITION_BITS-1:0];
                phase_next = (skip_len[POSITION_BITS-1:0] == '0) ? rhs_pkg::PH_HEADER
                                                                 : rhs_pkg::PH_SKIP;
                result.size = len_plus16[rhs_pkg::FIELD_BITS-1:0];
                result.status = rhs_pkg::ST_FOUND;
              end
            end
          end
        end
        default: begin
          phase_next = rhs_pkg::PH_STOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= rhs_pkg::PH_HEADER;
      header_count <= '0;
      byte_position <= '0;
      skip_remaining <= '0;
      crc_running <= rhs_pkg::CRC_ONES;
    end else begin
      phase <= phase_next;
      header_count <= header_count_next;
      byte_position <= byte_position_next;
      skip_remaining <= skip_remaining_next;
      crc_running <= crc_running_next;
    end
  end

  always_ff @(posedge clk) begin
    length_value <= length_value_next;
    len_plus16 <= len_plus16_next;
    stored_crc <= stored_crc_next;
    record_start <= record_start_next;
  end

endmodule

`default_nettype wire
